// ===== sv/time_set_command_parser_defines.svh =====
// Assertion macros for the time-set command parser.
// No dependencies; included by modules that carry concurrent checks.
`ifndef TIME_SET_COMMAND_PARSER_DEFINES_SVH
`define TIME_SET_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSCP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tscp_pkg.sv =====
// Shared types, state and event codes for the time-set command parser.
// No dependencies.
package tscp_pkg;

  localparam int unsigned StateW = 4;
  localparam int unsigned AccW   = 7;
  localparam int unsigned EventW = 3;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;

  // Parser states
  localparam logic [StateW-1:0] ST_IDLE = 4'd0;
  localparam logic [StateW-1:0] ST_BANG = 4'd1;
  localparam logic [StateW-1:0] ST_GOTT = 4'd2;
  localparam logic [StateW-1:0] ST_GOTI = 4'd3;
  localparam logic [StateW-1:0] ST_GOTM = 4'd4;
  localparam logic [StateW-1:0] ST_GOTE = 4'd5;
  localparam logic [StateW-1:0] ST_H1   = 4'd6;
  localparam logic [StateW-1:0] ST_H2   = 4'd7;
  localparam logic [StateW-1:0] ST_M1   = 4'd8;
  localparam logic [StateW-1:0] ST_M2   = 4'd9;
  localparam logic [StateW-1:0] ST_S1   = 4'd10;
  localparam logic [StateW-1:0] ST_S2   = 4'd11;
  localparam logic [StateW-1:0] ST_ACC  = 4'd12;

  typedef enum logic [EventW-1:0] {
    EV_NONE     = 3'd0,
    EV_NOTDIGIT = 3'd1,
    EV_HOUR     = 3'd2,
    EV_MINUTE   = 3'd3,
    EV_SECOND   = 3'd4,
    EV_OK       = 3'd5
  } event_e;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [AccW-1:0] HourMax   = 7'd23;
  localparam logic [AccW-1:0] MinSecMax = 7'd59;

  typedef struct packed {
    logic [StateW-1:0] parse_state;
    logic [AccW-1:0]   hour_acc;
    logic [AccW-1:0]   minute_acc;
    logic [AccW-1:0]   second_acc;
  } parse_t;

  typedef struct packed {
    logic [7:0]       echo_byte;
    event_e           event_res;
    logic [HourW-1:0] set_hour;
    logic [MinW-1:0]  set_minute;
    logic [MinW-1:0]  set_second;
  } result_t;

  // Expected byte in each header state; other states never use it.
  function automatic logic [7:0] hdr_expect(input logic [StateW-1:0] st);
    logic [7:0] ch;
    unique case (st)
      ST_BANG: ch = CH_T;
      ST_GOTT: ch = CH_I;
      ST_GOTI: ch = CH_M;
      ST_GOTM: ch = CH_E;
      ST_GOTE: ch = CH_COLON;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/tscp_if.sv =====
// Valid/ready channel interfaces for the time-set command parser.
// Depends on tscp_pkg.
interface tscp_in_if
  import tscp_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tscp_out_if
  import tscp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [7:0]       echo_byte;
  logic [EventW-1:0] event_res;
  logic [HourW-1:0] set_hour;
  logic [MinW-1:0]  set_minute;
  logic [MinW-1:0]  set_second;

  modport source (output valid, output echo_byte, output event_res, output set_hour,
                  output set_minute, output set_second, input ready);
  modport sink   (input valid, input echo_byte, input event_res, input set_hour,
                  input set_minute, input set_second, output ready);
endinterface

// ===== sv/tscp_step.sv =====
// Next-state and result logic for one received byte.
// Depends on tscp_pkg.
module tscp_step
  import tscp_pkg::*;
(
  input  parse_t     cur_i,
  input  logic [7:0] byte_i,
  output parse_t     nxt_o,
  output result_t    res_o
);

  logic            is_digit;
  logic [3:0]      digit;
  logic [AccW-1:0] tens;
  logic [AccW-1:0] sum_h;
  logic [AccW-1:0] sum_m;
  logic [AccW-1:0] sum_s;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit    = byte_i[3:0];
  // digit * 10 as shift-and-add
  assign tens  = {digit, 3'b000} + {2'b00, digit, 1'b0};
  assign sum_h = cur_i.hour_acc + {3'b000, digit};
  assign sum_m = cur_i.minute_acc + {3'b000, digit};
  assign sum_s = cur_i.second_acc + {3'b000, digit};

  always_comb begin
    nxt_o           = cur_i;
    res_o.echo_byte = byte_i;
    res_o.event_res = EV_NONE;
    res_o.set_hour  = '0;
    res_o.set_minute = '0;
    res_o.set_second = '0;
    unique case (cur_i.parse_state) inside
      [ST_BANG:ST_GOTE]: begin
        if (byte_i == hdr_expect(cur_i.parse_state)) begin
          nxt_o.parse_state = cur_i.parse_state + 4'd1;
        end else if (byte_i == CH_BANG) begin
          nxt_o.parse_state = ST_BANG;
        end else begin
          nxt_o.parse_state = ST_IDLE;
        end
      end
      [ST_H1:ST_S2]: begin
        if (!is_digit) begin
          res_o.event_res   = EV_NOTDIGIT;
          nxt_o.parse_state = ST_IDLE;
        end else begin
          unique case (cur_i.parse_state)
            ST_H1: begin
              nxt_o.hour_acc    = tens;
              nxt_o.parse_state = ST_H2;
            end
            ST_H2: begin
              nxt_o.hour_acc = sum_h;
              if (sum_h > HourMax) begin
                res_o.event_res   = EV_HOUR;
                nxt_o.parse_state = ST_IDLE;
              end else begin
                nxt_o.parse_state = ST_M1;
              end
            end
            ST_M1: begin
              nxt_o.minute_acc  = tens;
              nxt_o.parse_state = ST_M2;
            end
            ST_M2: begin
              nxt_o.minute_acc = sum_m;
              if (sum_m > MinSecMax) begin
                res_o.event_res   = EV_MINUTE;
                nxt_o.parse_state = ST_IDLE;
              end else begin
                nxt_o.parse_state = ST_S1;
              end
            end
            ST_S1: begin
              nxt_o.second_acc  = tens;
              nxt_o.parse_state = ST_S2;
            end
            default: begin
              nxt_o.second_acc = sum_s;
              if (sum_s > MinSecMax) begin
                res_o.event_res   = EV_SECOND;
                nxt_o.parse_state = ST_IDLE;
              end else begin
                nxt_o.parse_state = ST_ACC;
              end
            end
          endcase
        end
      end
      ST_ACC: begin
        if (byte_i == CH_HASH) begin
          res_o.event_res   = EV_OK;
          res_o.set_hour    = cur_i.hour_acc[HourW-1:0];
          res_o.set_minute  = cur_i.minute_acc[MinW-1:0];
          res_o.set_second  = cur_i.second_acc[MinW-1:0];
          nxt_o.parse_state = ST_IDLE;
        end
      end
      default: begin
        // idle and unused codes
        nxt_o.parse_state = (byte_i == CH_BANG) ? ST_BANG : ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/time_set_command_parser.sv =====
// Time-set command parser: recognizes "!TIME:HHMMSS#" in a byte stream.
// Receive side (in_ch) takes one character word per accepted handshake;
// transmit side (out_ch) returns exactly one result word per character:
// the echoed character, an event code, and on event "accepted" the time.
// A word accepted on in_ch waits in the input register, is decoded against
// the parser state and is registered in the result register. Throughput:
// one word per cycle while out_ch.ready is high; the state loop is a single
// register stage, so each word sees the state left by the one before it.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to idle with all field values zero.
// When the receiver holds out_ch.ready low, the result register holds its
// word; one more word may wait in the input register, after which
// in_ch.ready drops until the result is taken. No word is lost or repeated.
// Depends on tscp_pkg, tscp_if.sv, tscp_step and the defines header.
`include "time_set_command_parser_defines.svh"

module time_set_command_parser
  import tscp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tscp_in_if.sink     in_ch,
  tscp_out_if.source  out_ch
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res_d;
  parse_t     st_q;
  parse_t     st_d;
  logic       out_load;
  logic       fire;

  assign out_load    = !out_valid_q || out_ch.ready;
  assign fire        = in_valid_q && out_load;
  assign in_ch.ready = !in_valid_q || out_load;

  tscp_step u_step (
    .cur_i  (st_q),
    .byte_i (in_byte_q),
    .nxt_o  (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_q <= in_ch.valid;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_q <= in_ch.rx_byte;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.echo_byte  = res_q.echo_byte;
  assign out_ch.event_res  = res_q.event_res;
  assign out_ch.set_hour   = res_q.set_hour;
  assign out_ch.set_minute = res_q.set_minute;
  assign out_ch.set_second = res_q.set_second;

  `TSCP_ASSERT_IMPL(a_state_legal, 1'b1, st_q.parse_state <= ST_ACC, "parser state code unused")
  `TSCP_ASSERT_IMPL(a_time_range, out_valid_q && res_q.event_res == EV_OK,
    res_q.set_hour <= 5'd23 && res_q.set_minute <= 6'd59 && res_q.set_second <= 6'd59,
    "accepted time out of range")
  `TSCP_ASSERT_IMPL(a_time_zero, out_valid_q && res_q.event_res != EV_OK,
    res_q.set_hour == '0 && res_q.set_minute == '0 && res_q.set_second == '0,
    "time fields set without accept")
  `TSCP_ASSERT_NEXT(a_no_drop, in_valid_q && !out_load, in_valid_q && $stable(st_q),
    "pending word dropped or state moved while stalled")

endmodule

// ===== tb/sv/time_set_command_parser_tb.sv =====
// Self-checking testbench for the time-set command parser: streams characters through
// the receive channel, mirrors the parser state and checks every result word in order.
// Depends on tscp_pkg, the tscp_in_if/tscp_out_if interfaces and time_set_command_parser.
module time_set_command_parser_tb;
  import tscp_pkg::*;

  localparam int unsigned ItemTarget  = 1650;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 10;
  localparam logic [AccW-1:0] Radix   = 7'd10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tscp_in_if  in_ch ();
  tscp_out_if out_ch ();

  time_set_command_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mirror of the parser
  logic [StateW-1:0] mirror_st = ST_IDLE;
  logic [AccW-1:0]   hour_val  = '0;
  logic [AccW-1:0]   min_val   = '0;
  logic [AccW-1:0]   sec_val   = '0;

  logic [7:0]  char_q[$];
  result_t     pending_results[$];
  int unsigned chars_total  = 0;
  int unsigned chars_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int          tx_gap       = 0;
  int          rx_stall     = 0;
  int          hold_left    = 0;
  bit          tx_steady    = 1'b0;
  bit          rx_steady    = 1'b0;

  function automatic logic [7:0] digit_char(input int unsigned v);
    return CH_ZERO + 8'(v);
  endfunction

  // Advances the mirrored parser by one character and returns the word it should produce.
  function automatic result_t decode_char(input logic [7:0] ch);
    result_t         res;
    logic [7:0]      want;
    logic [AccW-1:0] digit;
    logic            is_digit;
    res           = '0;
    res.echo_byte = ch;
    res.event_res = EV_NONE;
    is_digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
    digit         = is_digit ? AccW'(ch - CH_ZERO) : '0;
    case (mirror_st)
      ST_BANG, ST_GOTT, ST_GOTI, ST_GOTM, ST_GOTE: begin
        case (mirror_st)
          ST_BANG: want = CH_T;
          ST_GOTT: want = CH_I;
          ST_GOTI: want = CH_M;
          ST_GOTM: want = CH_E;
          default: want = CH_COLON;
        endcase
        if (ch == want) mirror_st = mirror_st + 4'd1;
        else if (ch == CH_BANG) mirror_st = ST_BANG;
        else mirror_st = ST_IDLE;
      end
      ST_H1, ST_H2, ST_M1, ST_M2, ST_S1, ST_S2: begin
        if (!is_digit) begin
          // a bang here is just another non-digit
          res.event_res = EV_NOTDIGIT;
          mirror_st     = ST_IDLE;
        end else begin
          case (mirror_st)
            ST_H1: begin
              hour_val  = digit * Radix;
              mirror_st = ST_H2;
            end
            ST_H2: begin
              hour_val = hour_val + digit;
              if (hour_val > HourMax) begin
                res.event_res = EV_HOUR;
                mirror_st     = ST_IDLE;
              end else mirror_st = ST_M1;
            end
            ST_M1: begin
              min_val   = digit * Radix;
              mirror_st = ST_M2;
            end
            ST_M2: begin
              min_val = min_val + digit;
              if (min_val > MinSecMax) begin
                res.event_res = EV_MINUTE;
                mirror_st     = ST_IDLE;
              end else mirror_st = ST_S1;
            end
            ST_S1: begin
              sec_val   = digit * Radix;
              mirror_st = ST_S2;
            end
            default: begin
              sec_val = sec_val + digit;
              if (sec_val > MinSecMax) begin
                res.event_res = EV_SECOND;
                mirror_st     = ST_IDLE;
              end else mirror_st = ST_ACC;
            end
          endcase
        end
      end
      ST_ACC: begin
        if (ch == CH_HASH) begin
          res.event_res  = EV_OK;
          res.set_hour   = hour_val[HourW-1:0];
          res.set_minute = min_val[MinW-1:0];
          res.set_second = sec_val[MinW-1:0];
          mirror_st      = ST_IDLE;
        end
      end
      default: mirror_st = (ch == CH_BANG) ? ST_BANG : ST_IDLE;
    endcase
    return res;
  endfunction

  // Sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        pending_results.push_back(decode_char(in_ch.rx_byte));
        chars_taken++;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        in_ch.valid <= 1'b0;
      end else if (char_q.size() != 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= char_q.pop_front();
        if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
        tx_gap = tx_steady ? 0 : $urandom_range(0, 8);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.echo_byte  = out_ch.echo_byte;
        got.event_res  = event_e'(out_ch.event_res);
        got.set_hour   = out_ch.set_hour;
        got.set_minute = out_ch.set_minute;
        got.set_second = out_ch.set_second;
        if (pending_results.size() == 0) begin
          if (mismatch_cnt < MaxReports)
            $display("%0t: word with none pending: echo=%h ev=%0d time=%0d:%0d:%0d", $realtime,
                     got.echo_byte, got.event_res, got.set_hour, got.set_minute,
                     got.set_second);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.echo_byte !== want.echo_byte || got.event_res !== want.event_res ||
              got.set_hour !== want.set_hour || got.set_minute !== want.set_minute ||
              got.set_second !== want.set_second) begin
            if (mismatch_cnt < MaxReports)
              $display({"%0t: mismatch: got echo=%h ev=%0d time=%0d:%0d:%0d,",
                        " expected echo=%h ev=%0d time=%0d:%0d:%0d"},
                       $realtime, got.echo_byte, got.event_res, got.set_hour,
                       got.set_minute, got.set_second, want.echo_byte, want.event_res,
                       want.set_hour, want.set_minute, want.set_second);
            mismatch_cnt++;
          end
        end
        results_seen++;
        if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
        rx_stall = rx_steady ? 0 : $urandom_range(0, 8);
        // long back-pressure so the input side fills and stalls
        if (results_seen == 300 || results_seen == 1100) hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0]  cmd[$];
    int unsigned fld[3];
    int unsigned pos;
    int unsigned pad;

    // Directed: byte extremes, largest legal time with junk while waiting for the hash,
    // then a bang inside the header and an hour out of range.
    char_q = {8'h00, CH_BANG, CH_T, CH_I, CH_M, CH_E, CH_COLON,
              digit_char(2), digit_char(3), digit_char(5), digit_char(9),
              digit_char(5), digit_char(9), 8'hFF, CH_HASH,
              CH_BANG, CH_T, CH_BANG, CH_T, CH_I, CH_M, CH_E, CH_COLON,
              digit_char(2), digit_char(4)};

    // Mostly well-formed commands with random times, some corrupted; the rest is noise.
    while (char_q.size() < ItemTarget) begin
      if ($urandom_range(0, 3) != 0) begin
        foreach (fld[i]) begin
          if ($urandom_range(0, 5) == 0) fld[i] = $urandom_range((i == 0) ? 24 : 60, 99);
          else fld[i] = $urandom_range(0, (i == 0) ? 23 : 59);
        end
        cmd = {CH_BANG, CH_T, CH_I, CH_M, CH_E, CH_COLON};
        foreach (fld[i]) begin
          cmd.push_back(digit_char(fld[i] / 10));
          cmd.push_back(digit_char(fld[i] % 10));
        end
        pad = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        repeat (pad) cmd.push_back(8'($urandom_range(0, 255)));
        cmd.push_back(CH_HASH);
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, cmd.size() - 1);
          case ($urandom_range(0, 2))
            0:       cmd[pos] = 8'($urandom_range(0, 255));
            1:       cmd[pos] = CH_BANG;
            default: cmd = cmd[0:pos];
          endcase
        end
        char_q = {char_q, cmd};
      end else begin
        repeat ($urandom_range(1, 6))
          char_q.push_back(($urandom_range(0, 3) == 0) ? CH_BANG : 8'($urandom_range(0, 255)));
      end
    end
    chars_total = char_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (chars_taken != chars_total || pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
